// ----- sv/x86alu_pkg.sv -----
// shared types, constants and helpers for the x86 integer alu with flags
`default_nettype none

package x86alu_pkg;

	localparam int DATA_W = 64;
	localparam int CNT_W  = 6;
	localparam int FLAG_W = 6;

	// flag bit positions
	localparam int FL_CF = 0;
	localparam int FL_PF = 1;
	localparam int FL_AF = 2;
	localparam int FL_ZF = 3;
	localparam int FL_SF = 4;
	localparam int FL_OF = 5;

	// defined-flag masks
	localparam logic [FLAG_W-1:0] KN_NONE  = 6'h00;
	localparam logic [FLAG_W-1:0] KN_ALL   = 6'h3F;
	localparam logic [FLAG_W-1:0] KN_LOGIC = 6'h3B;
	localparam logic [FLAG_W-1:0] KN_PZS   = 6'h1A;
	localparam logic [FLAG_W-1:0] KN_CF    = 6'h01;
	localparam logic [FLAG_W-1:0] KN_OF    = 6'h20;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_CMP  = 3'd2,
		OP_TEST = 3'd3,
		OP_XOR  = 3'd4,
		OP_SHL  = 3'd5,
		OP_SHR  = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		WC_8  = 2'd0,
		WC_16 = 2'd1,
		WC_32 = 2'd2,
		WC_64 = 2'd3
	} wc_t;

	// decoded operation, stage 1
	typedef struct packed {
		op_t               op;
		wc_t               wc;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [CNT_W-1:0]  cnt;
		logic              cnt_ge64;
		logic              cnt_is1;
	} dec_t;

	// raw result and arithmetic flags, stage 2
	typedef struct packed {
		logic [DATA_W-1:0] r;
		wc_t               wc;
		logic              writes;
		logic              cf;
		logic              af;
		logic              of;
		logic [FLAG_W-1:0] known;
	} exe_t;

	// finished result beat, stage 3
	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic              writes_result;
		logic [FLAG_W-1:0] flags;
		logic [FLAG_W-1:0] flags_known;
	} rsp_t;

	function automatic logic [DATA_W-1:0] width_mask(input wc_t wc);
		logic [DATA_W-1:0] m;
		unique case (wc)
			WC_8:    m = 64'h0000_0000_0000_00FF;
			WC_16:   m = 64'h0000_0000_0000_FFFF;
			WC_32:   m = 64'h0000_0000_FFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic top_bit(input logic [DATA_W-1:0] v, input wc_t wc);
		logic t;
		unique case (wc)
			WC_8:    t = v[7];
			WC_16:   t = v[15];
			WC_32:   t = v[31];
			default: t = v[63];
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ----- sv/x86alu_if.sv -----
// valid/ready channel interfaces for request and response beats
`default_nettype none

interface x86alu_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [1:0]  width_code;
	logic [63:0] operand_a;
	logic [63:0] operand_b;

	modport source (output valid, output op, output width_code, output operand_a,
		output operand_b, input ready);
	modport sink (input valid, input op, input width_code, input operand_a,
		input operand_b, output ready);
	modport mon (input valid, input ready, input op, input width_code, input operand_a,
		input operand_b);
endinterface

interface x86alu_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result;
	logic        writes_result;
	logic [5:0]  flags;
	logic [5:0]  flags_known;

	modport source (output valid, output result, output writes_result, output flags,
		output flags_known, input ready);
	modport sink (input valid, input result, input writes_result, input flags,
		input flags_known, output ready);
	modport mon (input valid, input ready, input result, input writes_result,
		input flags, input flags_known);
endinterface

`default_nettype wire

// ----- sv/x86alu_decode.sv -----
// op decode, operand width masking and shift count split
`default_nettype none

module x86alu_decode
	import x86alu_pkg::*;
(
	input  wire logic [2:0]        op,
	input  wire logic [1:0]        width_code,
	input  wire logic [DATA_W-1:0] operand_a,
	input  wire logic [DATA_W-1:0] operand_b,
	output dec_t                   dec
);

	op_t               op_d;
	logic              is_shift;
	logic [DATA_W-1:0] mask;

	always_comb begin
		op_d     = op_t'(op);
		is_shift = (op_d == OP_SHL) || (op_d == OP_SHR);
		mask     = width_mask(wc_t'(width_code));

		dec.op       = op_d;
		dec.cnt      = operand_b[CNT_W-1:0];
		dec.cnt_ge64 = |operand_b[7:CNT_W];
		dec.cnt_is1  = (operand_b[7:0] == 8'd1);
		if (is_shift) begin
			dec.wc = WC_64;
			dec.a  = operand_a;
			dec.b  = operand_b;
		end else begin
			dec.wc = wc_t'(width_code);
			dec.a  = operand_a & mask;
			dec.b  = operand_b & mask;
		end
	end

endmodule

`default_nettype wire

// ----- sv/x86alu_exec.sv -----
// adder, subtractor, logic and barrel shifter with carry, adjust and overflow
`default_nettype none

module x86alu_exec
	import x86alu_pkg::*;
(
	input  wire dec_t dec,
	output exe_t exe
);

	logic [DATA_W:0]   sum;
	logic [DATA_W:0]   diff;
	logic [DATA_W-1:0] mask;
	logic [DATA_W-1:0] r_add;
	logic [DATA_W-1:0] r_sub;
	logic [DATA_W-1:0] r_shl;
	logic [DATA_W-1:0] r_shr;
	logic              add_cf;
	logic [CNT_W-1:0]  neg_cnt;
	logic [CNT_W-1:0]  cnt_m1;
	logic              shl_cf;
	logic              shr_cf;
	logic [FLAG_W-1:0] shift_known;

	always_comb begin
		mask  = width_mask(dec.wc);
		sum   = {1'b0, dec.a} + {1'b0, dec.b};
		diff  = {1'b0, dec.a} - {1'b0, dec.b};
		r_add = sum[DATA_W-1:0] & mask;
		r_sub = diff[DATA_W-1:0] & mask;
		unique case (dec.wc)
			WC_8:    add_cf = sum[8];
			WC_16:   add_cf = sum[16];
			WC_32:   add_cf = sum[32];
			default: add_cf = sum[DATA_W];
		endcase

		r_shl   = dec.a << dec.cnt;
		r_shr   = dec.a >> dec.cnt;
		neg_cnt = (~dec.cnt) + 6'd1;
		cnt_m1  = dec.cnt - 6'd1;
		shl_cf  = dec.a[neg_cnt];
		shr_cf  = dec.a[cnt_m1];

		// zero count leaves every flag unknown
		if (dec.cnt == '0) begin
			shift_known = KN_NONE;
		end else begin
			shift_known = KN_PZS | (dec.cnt_ge64 ? KN_NONE : KN_CF)
				| (dec.cnt_is1 ? KN_OF : KN_NONE);
		end

		exe.wc     = dec.wc;
		exe.r      = '0;
		exe.writes = 1'b0;
		exe.cf     = 1'b0;
		exe.af     = 1'b0;
		exe.of     = 1'b0;
		exe.known  = KN_NONE;
		unique case (dec.op)
			OP_ADD: begin
				exe.r      = r_add;
				exe.writes = 1'b1;
				exe.cf     = add_cf;
				exe.af     = dec.a[4] ^ dec.b[4] ^ r_add[4];
				exe.of     = top_bit((dec.a ^ r_add) & (dec.b ^ r_add), dec.wc);
				exe.known  = KN_ALL;
			end
			OP_SUB, OP_CMP: begin
				exe.r      = r_sub;
				exe.writes = (dec.op == OP_SUB);
				exe.cf     = diff[DATA_W];
				exe.af     = dec.a[4] ^ dec.b[4] ^ r_sub[4];
				exe.of     = top_bit((dec.a ^ dec.b) & (dec.a ^ r_sub), dec.wc);
				exe.known  = KN_ALL;
			end
			OP_TEST: begin
				exe.r     = dec.a & dec.b;
				exe.known = KN_LOGIC;
			end
			OP_XOR: begin
				exe.r      = dec.a ^ dec.b;
				exe.writes = 1'b1;
				exe.known  = KN_LOGIC;
			end
			OP_SHL: begin
				exe.r      = r_shl;
				exe.writes = 1'b1;
				exe.cf     = shl_cf;
				exe.of     = r_shl[DATA_W-1] ^ shl_cf;
				exe.known  = shift_known;
			end
			OP_SHR: begin
				exe.r      = r_shr;
				exe.writes = 1'b1;
				exe.cf     = shr_cf;
				exe.of     = dec.a[DATA_W-1];
				exe.known  = shift_known;
			end
			default: begin
				exe.r = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/x86alu_flags.sv -----
// parity, zero and sign flags and final result beat assembly
`default_nettype none

module x86alu_flags
	import x86alu_pkg::*;
(
	input  wire exe_t exe,
	output rsp_t rsp
);

	logic              pf;
	logic              zf;
	logic              sf;
	logic [FLAG_W-1:0] raw;

	always_comb begin
		pf  = ~(^exe.r[7:0]);
		zf  = (exe.r == '0);
		sf  = top_bit(exe.r, exe.wc);
		raw = '0;
		raw[FL_CF] = exe.cf;
		raw[FL_PF] = pf;
		raw[FL_AF] = exe.af;
		raw[FL_ZF] = zf;
		raw[FL_SF] = sf;
		raw[FL_OF] = exe.of;

		rsp.result        = exe.writes ? exe.r : '0;
		rsp.writes_result = exe.writes;
		rsp.flags         = raw & exe.known;
		rsp.flags_known   = exe.known;
	end

endmodule

`default_nettype wire

// ----- sv/x86_integer_alu_flags.sv -----
// top level: three-stage x86 integer alu with flag reporting
// stages: decode, execute and flags, each ending in a register, from request beat to response beat
// throughput: one beat per cycle unless the response stalls; every stage is a register with its own valid bit
// a stalled response holds the pipe in place, emptied stages still fill
// reset: arst_n clears all stage valid bits asynchronously; payload is not reset
`default_nettype none

module x86_integer_alu_flags
	import x86alu_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	x86alu_req_if.sink    req,
	x86alu_rsp_if.source  rsp
);

	dec_t dec_d;
	exe_t exe_d;
	rsp_t rsp_d;

	dec_t dec_s1;
	exe_t exe_s2;
	rsp_t rsp_s3;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;

	logic adv_s1;
	logic adv_s2;
	logic adv_s3;

	x86alu_decode u_decode (
		.op         (req.op),
		.width_code (req.width_code),
		.operand_a  (req.operand_a),
		.operand_b  (req.operand_b),
		.dec        (dec_d)
	);

	x86alu_exec u_exec (
		.dec (dec_s1),
		.exe (exe_d)
	);

	x86alu_flags u_flags (
		.exe (exe_s2),
		.rsp (rsp_d)
	);

	assign adv_s3 = !valid_s3 || rsp.ready;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;

	assign req.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= req.valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) dec_s1 <= dec_d;
		if (adv_s2 && valid_s1) exe_s2 <= exe_d;
		if (adv_s3 && valid_s2) rsp_s3 <= rsp_d;
	end

	assign rsp.valid         = valid_s3;
	assign rsp.result        = rsp_s3.result;
	assign rsp.writes_result = rsp_s3.writes_result;
	assign rsp.flags         = rsp_s3.flags;
	assign rsp.flags_known   = rsp_s3.flags_known;

endmodule

`default_nettype wire

// ----- sv/x86alu_checker.sv -----
// port-level checks for the alu and their bind to the top level
`default_nettype none

module x86alu_port_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [63:0] rsp_result,
	input wire logic        rsp_writes_result,
	input wire logic [5:0]  rsp_flags,
	input wire logic [5:0]  rsp_flags_known
);

	// a stalled response beat stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response beat dropped while stalled");

	// a stalled response beat keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_result) && $stable(rsp_flags)
			&& $stable(rsp_flags_known) && $stable(rsp_writes_result))
		else $error("response payload changed while stalled");

	// without a stalled response the pipe always takes a request
	assert property (@(posedge clk) disable iff (!arst_n)
		!(rsp_valid && !rsp_ready) |-> req_ready)
		else $error("request refused with free pipe");

	// unknown flags read as zero
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_flags & ~rsp_flags_known) == 6'd0))
		else $error("flag set without being defined");

	// no write means a zero result
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_writes_result |-> (rsp_result == 64'd0))
		else $error("nonzero result without write");

endmodule

bind x86_integer_alu_flags x86alu_port_checker u_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_result        (rsp.result),
	.rsp_writes_result (rsp.writes_result),
	.rsp_flags         (rsp.flags),
	.rsp_flags_known   (rsp.flags_known)
);

`default_nettype wire

// ----- tb/x86alu_checker.sv -----
// response checker for the x86 integer alu: predicts each request beat and compares the responses
`default_nettype none

module x86alu_checker
	import x86alu_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	x86alu_req_if.mon  req,
	x86alu_rsp_if.mon  rsp,
	output int         mismatches,
	output int         in_flight
);

	rsp_t results_due[$];

	initial begin
		mismatches = 0;
		in_flight  = 0;
	end

	// parity, zero and sign of a result already cut to its width
	function automatic logic [FLAG_W-1:0] pzs_of(input logic [DATA_W-1:0] r, input int unsigned top);
		logic [FLAG_W-1:0] f;
		f         = '0;
		f[FL_PF]  = ~^r[7:0];
		f[FL_ZF]  = (r == '0);
		f[FL_SF]  = r[top];
		return f;
	endfunction

	function automatic rsp_t alu_predict(input logic [2:0] op, input logic [1:0] wc,
		input logic [DATA_W-1:0] a_in, input logic [DATA_W-1:0] b_in);
		rsp_t              p;
		int unsigned       nbits;
		logic [DATA_W-1:0] m;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] r;
		logic [DATA_W:0]   wide;
		logic              sa;
		logic              sb;
		logic              sr;
		logic              cf;
		logic              of;
		logic [7:0]        raw;
		logic [CNT_W-1:0]  cnt;
		nbits = 8 << wc;
		m     = (nbits == DATA_W) ? '1 : ((64'd1 << nbits) - 64'd1);
		a     = a_in & m;
		b     = b_in & m;
		p     = '0;
		case (op)
			OP_ADD, OP_SUB, OP_CMP: begin
				if (op == OP_ADD) begin
					wide = {1'b0, a} + {1'b0, b};
				end else begin
					wide = {1'b0, a} - {1'b0, b};
				end
				r  = wide[DATA_W-1:0] & m;
				sa = a[nbits-1];
				sb = b[nbits-1];
				sr = r[nbits-1];
				if (op == OP_ADD) begin
					of = (sa == sb) && (sr != sa);
				end else begin
					of = (sa != sb) && (sr != sa);
				end
				p.flags         = pzs_of(r, nbits - 1);
				p.flags[FL_CF]  = wide[nbits];
				p.flags[FL_AF]  = a[4] ^ b[4] ^ r[4];
				p.flags[FL_OF]  = of;
				p.flags_known   = KN_ALL;
				p.writes_result = (op != OP_CMP);
				p.result        = p.writes_result ? r : '0;
			end
			OP_TEST, OP_XOR: begin
				r               = (op == OP_TEST) ? (a & b) : (a ^ b);
				p.flags         = pzs_of(r, nbits - 1);
				p.flags_known   = KN_LOGIC;
				p.writes_result = (op == OP_XOR);
				p.result        = p.writes_result ? r : '0;
			end
			OP_SHL, OP_SHR: begin
				raw             = b_in[7:0];
				cnt             = raw[CNT_W-1:0];
				p.writes_result = 1'b1;
				if (cnt == '0) begin
					p.result = a_in;
				end else begin
					if (op == OP_SHL) begin
						r  = a_in << cnt;
						cf = a_in[DATA_W - int'(cnt)];
						of = r[DATA_W-1] ^ cf;
					end else begin
						r  = a_in >> cnt;
						cf = a_in[int'(cnt) - 1];
						of = a_in[DATA_W-1];
					end
					p.result      = r;
					p.flags       = pzs_of(r, DATA_W - 1);
					p.flags_known = KN_PZS;
					if (raw < 8'd64) begin
						p.flags_known  = p.flags_known | KN_CF;
						p.flags[FL_CF] = cf;
					end
					if (raw == 8'd1) begin
						p.flags_known  = p.flags_known | KN_OF;
						p.flags[FL_OF] = of;
					end
				end
			end
			default: begin
				p = '0;
			end
		endcase
		return p;
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		int   delta;
		int   errs;
		delta = 0;
		errs  = 0;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (results_due.size() == 0) begin
					$error("response beat with no request beat waiting");
					errs++;
				end else begin
					want = results_due.pop_front();
					delta--;
					if (rsp.result !== want.result) begin
						$error("result: expected %h, got %h", want.result, rsp.result);
						errs++;
					end
					if (rsp.writes_result !== want.writes_result) begin
						$error("writes_result: expected %b, got %b", want.writes_result,
							rsp.writes_result);
						errs++;
					end
					if (rsp.flags !== want.flags) begin
						$error("flags: expected %b, got %b", want.flags, rsp.flags);
						errs++;
					end
					if (rsp.flags_known !== want.flags_known) begin
						$error("flags_known: expected %b, got %b", want.flags_known,
							rsp.flags_known);
						errs++;
					end
				end
			end
			if (req.valid && req.ready) begin
				results_due.push_back(alu_predict(req.op, req.width_code, req.operand_a,
					req.operand_b));
				delta++;
			end
		end
		in_flight  <= in_flight + delta;
		mismatches <= mismatches + errs;
	end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench top for the x86 integer alu: clock, reset, request and response pacing, verdict
`default_nettype none

module tb_top;
	import x86alu_pkg::*;

	localparam logic [2:0] OP_ILLEGAL  = 3'd7;
	localparam int         CYCLE_LIMIT = 1000000;
	localparam int         RAND_BEATS  = 1200;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   in_flight;
	int   cycle_count;
	int   rsp_hold;
	bit   quiet_on;

	x86alu_req_if req_ch ();
	x86alu_rsp_if rsp_ch ();

	x86_integer_alu_flags u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	x86alu_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.in_flight  (in_flight)
	);

	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		cycle_count         = 0;
		rsp_hold            = 0;
		quiet_on            = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.op           = '0;
		req_ch.width_code   = '0;
		req_ch.operand_a    = '0;
		req_ch.operand_b    = '0;
		rsp_ch.ready        = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// mostly short stalls, a few long ones
	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 70) return $urandom_range(1, 3);
		if (k < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold     <= 0;
		end else if (rsp_hold != 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold     <= rsp_hold - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (!quiet_on && $urandom_range(0, 3) == 0) begin
				rsp_hold <= pick_gap();
			end
		end
	end

	task automatic send_beat(input logic [2:0] op, input logic [1:0] wc,
		input logic [63:0] a, input logic [63:0] b);
		int gap;
		gap = (!quiet_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.op         <= op;
		req_ch.width_code <= wc;
		req_ch.operand_a  <= a;
		req_ch.operand_b  <= b;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
	endtask

	// edge values at the operand width or fully random ones, edge values sometimes with junk above the width
	function automatic logic [63:0] pick_operand(input logic [1:0] wc);
		int unsigned nbits;
		logic [63:0] m;
		logic [63:0] v;
		int          k;
		nbits = 8 << wc;
		m     = (nbits == 64) ? '1 : ((64'd1 << nbits) - 64'd1);
		k     = $urandom_range(0, 9);
		case (k)
			0:       v = '0;
			1:       v = '1;
			2:       v = 64'd1 << (nbits - 1);
			3:       v = (64'd1 << (nbits - 1)) - 64'd1;
			4:       v = 64'($urandom_range(0, 31));
			default: v = {$urandom, $urandom};
		endcase
		if (k < 5 && $urandom_range(0, 1) == 1) begin
			v = (v & m) | ({$urandom, $urandom} & ~m);
		end
		return v;
	endfunction

	function automatic logic [63:0] pick_count();
		logic [63:0] v;
		int          k;
		v = {$urandom, $urandom};
		k = $urandom_range(0, 9);
		case (k)
			0: v[7:0] = 8'd0;
			1: v[7:0] = 8'd1;
			2: v[7:0] = 8'd63;
			3: v[7:0] = 8'd64;
			4: v[7:0] = 8'd65;
			5: v[7:0] = 8'd1;
			6: v[7:0] = 8'($urandom_range(0, 63));
			default: v[7:0] = 8'($urandom_range(0, 255));
		endcase
		return v;
	endfunction

	initial begin
		logic [2:0]  op;
		logic [1:0]  wc;
		logic [63:0] a;
		logic [63:0] b;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(OP_ADD,  WC_8,  64'hDEAD_BEEF_0000_00FF, 64'h1);
		send_beat(OP_ADD,  WC_64, 64'h7FFF_FFFF_FFFF_FFFF, 64'h1);
		send_beat(OP_ADD,  WC_64, '1, '1);
		send_beat(OP_ADD,  WC_16, '0, '0);
		send_beat(OP_SUB,  WC_16, '0, 64'h1);
		send_beat(OP_SUB,  WC_32, 64'h8000_0000, 64'h1);
		send_beat(OP_SUB,  WC_64, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
		send_beat(OP_CMP,  WC_8,  64'h55, 64'h55);
		send_beat(OP_CMP,  WC_64, 64'h1, '1);
		send_beat(OP_TEST, WC_16, 64'hFFFF_8000, 64'hFFFF_FFFF);
		send_beat(OP_TEST, WC_64, '1, '1);
		send_beat(OP_XOR,  WC_8,  64'h1234_5678_9ABC_DEF0, 64'h0000_0000_0000_00F0);
		send_beat(OP_XOR,  WC_32, 64'hFFFF_FFFF_0F0F_0F0F, 64'h0000_0000_F0F0_F0F0);
		send_beat(OP_XOR,  WC_64, '1, '0);
		send_beat(OP_SHL,  WC_8,  64'h8000_0000_0000_0001, 64'h0);
		send_beat(OP_SHL,  WC_64, 64'hC000_0000_0000_0000, 64'h1);
		send_beat(OP_SHL,  WC_32, 64'h1, 64'h3F);
		send_beat(OP_SHL,  WC_64, '1, 64'h40);
		send_beat(OP_SHL,  WC_16, 64'h3, 64'hFFFF_FF41);
		send_beat(OP_SHR,  WC_64, 64'h8000_0000_0000_0001, 64'h1);
		send_beat(OP_SHR,  WC_64, '1, 64'h3F);
		send_beat(OP_SHR,  WC_8,  64'h1234, 64'hFF);
		send_beat(OP_SHR,  WC_64, 64'hF, 64'h80);
		send_beat(OP_ILLEGAL, WC_64, '1, '1);

		for (int i = 0; i < RAND_BEATS; i++) begin
			if (i == 400) quiet_on = 1'b1;
			if (i == 600) quiet_on = 1'b0;
			if (i == 800) drain();
			op = ($urandom_range(0, 99) < 2) ? OP_ILLEGAL : 3'($urandom_range(0, 6));
			wc = 2'($urandom_range(0, 3));
			a  = pick_operand((op == OP_SHL || op == OP_SHR) ? WC_64 : wc);
			if (op == OP_SHL || op == OP_SHR) begin
				b = pick_count();
			end else if ($urandom_range(0, 7) == 0) begin
				b = a;
			end else begin
				b = pick_operand(wc);
			end
			send_beat(op, wc, a, b);
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
